// ===== hdl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and character codes for the C string escape encoder.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_QUOTE     = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_QMARK     = 8'h3f;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DEL       = 8'h7f;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;

  localparam logic [1:0] POS_FIRST = 2'd0;

  // one classified byte: up to four characters and the index of the last one
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_pos;
  } cse_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } cse_queue_status_t;

endpackage

// ===== hdl/cse_classify.sv =====
// ----------------------------------------------------------------------------
// cse_classify
// Front part: turns one raw byte into its escaped run of characters.
// ----------------------------------------------------------------------------
module cse_classify (
  input  logic [7:0]          in_byte,
  output cse_pkg::cse_entry_t entry
);

  logic [7:0] letter;
  logic       has_letter;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = cse_pkg::CHAR_ZERO + ext;
    end else begin
      hex_char = cse_pkg::CHAR_LOWER_A + ext - 8'd10;
    end
  endfunction

  always_comb begin
    has_letter = 1'b1;
    unique case (in_byte)
      8'd0:    letter = 8'h30;
      8'd7:    letter = 8'h61;
      8'd8:    letter = 8'h62;
      8'd9:    letter = 8'h74;
      8'd10:   letter = 8'h6e;
      8'd11:   letter = 8'h76;
      8'd12:   letter = 8'h66;
      8'd13:   letter = 8'h72;
      8'd27:   letter = 8'h65;
      default: begin
        letter     = 8'h00;
        has_letter = 1'b0;
      end
    endcase
  end

  always_comb begin
    entry.chars    = '0;
    entry.last_pos = cse_pkg::POS_FIRST;
    if (in_byte == cse_pkg::CHAR_BACKSLASH || in_byte == cse_pkg::CHAR_QUOTE ||
        in_byte == cse_pkg::CHAR_DQUOTE || in_byte == cse_pkg::CHAR_QMARK) begin
      entry.chars[0] = cse_pkg::CHAR_BACKSLASH;
      entry.chars[1] = in_byte;
      entry.last_pos = 2'd1;
    end else if (in_byte >= cse_pkg::CHAR_SPACE && in_byte != cse_pkg::CHAR_DEL) begin
      entry.chars[0] = in_byte;
    end else if (has_letter) begin
      entry.chars[0] = cse_pkg::CHAR_BACKSLASH;
      entry.chars[1] = letter;
      entry.last_pos = 2'd1;
    end else begin
      entry.chars[0] = cse_pkg::CHAR_BACKSLASH;
      entry.chars[1] = cse_pkg::CHAR_X;
      entry.chars[2] = hex_char(in_byte[7:4]);
      entry.chars[3] = hex_char(in_byte[3:0]);
      entry.last_pos = 2'd3;
    end
  end

endmodule

// ===== hdl/cse_queue.sv =====
// ----------------------------------------------------------------------------
// cse_queue
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module cse_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  cse_pkg::cse_entry_t        wr_entry,
  input  logic                       rd_en,
  output cse_pkg::cse_entry_t        rd_entry,
  output cse_pkg::cse_queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cse_pkg::cse_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cse_emit.sv =====
// ----------------------------------------------------------------------------
// cse_emit
// Back part: holds one entry and hands out its characters one per pop.
// ----------------------------------------------------------------------------
module cse_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cse_pkg::cse_entry_t q_entry,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_char,
  output logic                run_last
);

  cse_pkg::cse_entry_t ent;
  logic                busy;
  logic [1:0]          pos;
  logic                take;

  assign run_last = (pos == ent.last_pos);
  assign out_char = ent.chars[pos];
  assign empty    = !busy;
  // free now, or the last character of the run leaves this cycle
  assign take     = !busy || (pop && run_last);
  assign q_rd     = take && !q_empty;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ent <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= cse_pkg::POS_FIRST;
    end else if (take) begin
      busy <= !q_empty;
      pos  <= cse_pkg::POS_FIRST;
    end else if (pop) begin
      pos <= pos + 1'b1;
    end
  end

  a_pos_in_run: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= ent.last_pos)
    else $error("emit position beyond end of run");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (busy && pop && !run_last) |=> (busy && pos == $past(pos) + 2'd1))
    else $error("run cut short");

  a_escape_prefix: assert property (@(posedge clk) disable iff (rst)
    (busy && ent.last_pos != cse_pkg::POS_FIRST) |->
      ent.chars[0] == cse_pkg::CHAR_BACKSLASH)
    else $error("escape run without backslash");

endmodule

// ===== hdl/c_string_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// c_string_escape_encoder
// C-style escaping of a byte stream, one to four characters per byte.
// ----------------------------------------------------------------------------
// input side: a queue interface; a byte is taken when push is high and full
//   is low. each byte is classified at once and its run of characters is
//   written into a queue of FIFO_DEPTH entries.
// result side: the oldest character stands on out_char/run_last while empty
//   is low and leaves when pop is high; run_last marks the end of a byte's run.
// path: a byte is written into the queue at the edge that takes it, then
//   loaded into the output stage, where its first character appears.
// throughput: one character per cycle at the output while pop is high and a
//   run is waiting; plain bytes (run of one) flow at one byte per cycle; an
//   escape run is 2 or 4 characters; the input fills the queue until full.
// when pop stays low the characters hold and the queue fills; full then
//   rises and input stops. nothing is dropped.
// reset (rst, synchronous) empties the queue and the output stage.
// ----------------------------------------------------------------------------
module c_string_escape_encoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       run_last
);

  cse_pkg::cse_entry_t        cls_entry;
  cse_pkg::cse_entry_t        q_entry;
  cse_pkg::cse_queue_status_t q_status;
  logic                       q_rd;

  assign full = q_status.full;

  cse_classify u_classify (
    .in_byte (in_byte),
    .entry   (cls_entry)
  );

  cse_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_entry (cls_entry),
    .rd_en    (q_rd),
    .rd_entry (q_entry),
    .status   (q_status)
  );

  cse_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_status.empty),
    .q_entry  (q_entry),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .run_last (run_last)
  );

endmodule
